// ----- rtl/pps_pkg.sv -----
// shared constants, types and arithmetic steps of the point light shader
package pps_pkg;

  localparam int UNIT_SHIFT = 30;
  localparam int ISQ_STEPS  = 32;
  localparam int DIV_STEPS  = 31;
  localparam int NORM_LAT   = 4 + ISQ_STEPS + 1 + DIV_STEPS + 1;
  localparam int SHADE_LAT  = 12;

  localparam logic [30:0] UNIT_ONE  = 31'(64'd1 << UNIT_SHIFT);
  localparam logic [63:0] HALF_Q30  = 64'd1 << (UNIT_SHIFT - 1);
  localparam logic [63:0] HALF_OUT  = 64'd1 << 45;
  localparam logic [16:0] W_ONE     = 17'd65536;
  localparam logic [16:0] W_SIX     = 17'd39322;
  localparam logic [31:0] SPEC_ONE  = 32'd3435986944;
  localparam logic [31:0] SPEC_FOUR = 32'd1374373806;
  localparam logic [15:0] OUT_MAX   = 16'hFFFF;

  typedef enum logic [1:0] {
    MODE_REFLECT = 2'd0,
    MODE_DIFFUSE = 2'd1,
    MODE_FRESNEL = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    REG_LIGHT_X = 2'd0,
    REG_LIGHT_Y = 2'd1,
    REG_LIGHT_Z = 2'd2,
    REG_MODE    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [63:0] x;
    logic [63:0] r;
  } isq_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [30:0] low;
    logic [30:0] quo;
  } dvs_t;

  // one digit of the square root
  function automatic isq_t isq_step(isq_t s, logic [63:0] b);
    isq_t o;
    logic [63:0] t;
    t = s.r + b;
    if (s.x >= t) begin
      o.x = s.x - t;
      o.r = (s.r >> 1) + b;
    end else begin
      o.x = s.x;
      o.r = s.r >> 1;
    end
    return o;
  endfunction

  // one quotient bit of the restoring divide
  function automatic dvs_t div_step(dvs_t s, logic [31:0] len);
    dvs_t o;
    logic [32:0] t;
    t = {s.rem, s.low[30]};
    o.low = {s.low[29:0], 1'b0};
    if (t >= {1'b0, len}) begin
      o.rem = 32'(t - {1'b0, len});
      o.quo = {s.quo[29:0], 1'b1};
    end else begin
      o.rem = t[31:0];
      o.quo = {s.quo[29:0], 1'b0};
    end
    return o;
  endfunction

endpackage

// ----- rtl/pps_if.sv -----
// sample and pixel channel interfaces
interface pps_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic signed [31:0] norm_x, norm_y, norm_z;
  logic signed [31:0] eye_x, eye_y, eye_z;
  logic [15:0] base_red, base_green, base_blue;
  modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                  eye_x, eye_y, eye_z, base_red, base_green, base_blue, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                eye_x, eye_y, eye_z, base_red, base_green, base_blue, output ready);
endinterface

interface pps_out_if;
  logic valid;
  logic ready;
  logic [15:0] shade_red, shade_green, shade_blue;
  modport source (output valid, shade_red, shade_green, shade_blue, input ready);
  modport sink (input valid, shade_red, shade_green, shade_blue, output ready);
endinterface

// ----- rtl/phong_point_light_shader.sv -----
// top level of the point light phong shader
//
// sample: one surface sample per transfer (position, normal, eye, base colour)
// pixel: one shaded colour per sample, in the order the samples arrived
// cfg: write port for the light position and the material mode; write it
//   only while no sample is in flight
// latency: 81 cycles from a sample transfer to its pixel showing valid, set by
//   the 32-digit square root and the 31-bit restoring divide of the
//   normalisers plus the dot product and seventh power stages
// throughput: one sample per cycle, every stage holds one sample
// stall: when pixel is valid and not taken the whole pipeline freezes and
//   sample ready drops; nothing is lost or repeated, bubbles stay in place
// reset: empties the pipeline, light at the origin, diffuse mode
module phong_point_light_shader (
  input  logic        clk,
  input  logic        rst,
  pps_in_if.sink      sample,
  pps_out_if.source   pixel,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic signed [31:0] light_x, light_y, light_z;
  pps_pkg::mode_t mode;

  logic en;
  logic [pps_pkg::NORM_LAT:0] vq;
  logic [15:0] colq [pps_pkg::NORM_LAT+1][3];

  logic signed [32:0] nr_a [3];
  logic signed [32:0] ev_a [3];
  logic signed [32:0] lv_a [3];
  logic signed [31:0] n_u [3];
  logic signed [31:0] v_u [3];
  logic signed [31:0] l_u [3];
  logic [15:0] rgb [3];
  logic sh_valid;

  assign en = !pixel.valid || pixel.ready;
  assign sample.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_x <= '0;
      light_y <= '0;
      light_z <= '0;
      mode    <= pps_pkg::MODE_DIFFUSE;
    end else if (cfg_we) begin
      unique case (pps_pkg::reg_idx_t'(cfg_index))
        pps_pkg::REG_LIGHT_X: light_x <= cfg_data;
        pps_pkg::REG_LIGHT_Y: light_y <= cfg_data;
        pps_pkg::REG_LIGHT_Z: light_z <= cfg_data;
        pps_pkg::REG_MODE:    mode    <= pps_pkg::mode_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vq <= '0;
    end else if (en) begin
      vq <= {vq[pps_pkg::NORM_LAT-1:0], sample.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nr_a[0] <= 33'(sample.norm_x);
      nr_a[1] <= 33'(sample.norm_y);
      nr_a[2] <= 33'(sample.norm_z);
      ev_a[0] <= 33'(sample.eye_x) - 33'(sample.pos_x);
      ev_a[1] <= 33'(sample.eye_y) - 33'(sample.pos_y);
      ev_a[2] <= 33'(sample.eye_z) - 33'(sample.pos_z);
      lv_a[0] <= 33'(light_x) - 33'(sample.pos_x);
      lv_a[1] <= 33'(light_y) - 33'(sample.pos_y);
      lv_a[2] <= 33'(light_z) - 33'(sample.pos_z);
      colq[0][0] <= sample.base_red;
      colq[0][1] <= sample.base_green;
      colq[0][2] <= sample.base_blue;
      for (int k = 1; k <= pps_pkg::NORM_LAT; k++) begin
        colq[k] <= colq[k-1];
      end
    end
  end

  pps_normalize u_norm_n (.clk(clk), .en(en), .vec(nr_a), .unit_vec(n_u));
  pps_normalize u_norm_v (.clk(clk), .en(en), .vec(ev_a), .unit_vec(v_u));
  pps_normalize u_norm_l (.clk(clk), .en(en), .vec(lv_a), .unit_vec(l_u));

  pps_shade u_shade (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(vq[pps_pkg::NORM_LAT]),
    .nrm(n_u),
    .eye_dir(v_u),
    .lgt_dir(l_u),
    .color(colq[pps_pkg::NORM_LAT]),
    .mode(mode),
    .out_valid(sh_valid),
    .rgb(rgb)
  );

  assign pixel.valid       = sh_valid;
  assign pixel.shade_red   = rgb[0];
  assign pixel.shade_green = rgb[1];
  assign pixel.shade_blue  = rgb[2];

  // a frozen pipeline keeps its occupancy
  a_stall_hold: assert property (@(posedge clk) disable iff (rst) !en |=> $stable(vq))
    else $error("valid chain moved during a stall");

  a_reset_regs: assert property (@(posedge clk)
    $past(rst) |-> (mode == pps_pkg::MODE_DIFFUSE && light_x == '0 && light_z == '0))
    else $error("configuration not at reset values");

  a_reset_empty: assert property (@(posedge clk) rst |=> (!pixel.valid && vq == '0))
    else $error("pipeline not empty after reset");

endmodule

// ----- rtl/pps_normalize.sv -----
// pipelined vector normaliser: prescale, sum of squares, square root, divide
module pps_normalize (
  input  logic               clk,
  input  logic               en,
  input  logic signed [32:0] vec [3],
  output logic signed [31:0] unit_vec [3]
);

  logic [31:0] mag [3];
  logic [31:0] big;
  logic [31:0] s1_mag [3];
  logic [31:0] s1_big;
  logic [2:0]  s1_neg;

  logic [4:0]  lead;
  logic [30:0] nm [3];
  logic [30:0] s2_m [3];
  logic        s2_zero;
  logic [2:0]  s2_neg;

  logic [61:0] s3_sq [3];
  logic [30:0] s3_m [3];
  logic        s3_zero;
  logic [2:0]  s3_neg;

  pps_pkg::isq_t isq [pps_pkg::ISQ_STEPS+1];
  logic [30:0] pm [pps_pkg::ISQ_STEPS+1][3];
  logic        pz [pps_pkg::ISQ_STEPS+1];
  logic [2:0]  pn [pps_pkg::ISQ_STEPS+1];

  logic [31:0] len;
  logic [61:0] dvd [3];

  pps_pkg::dvs_t dv [pps_pkg::DIV_STEPS+1][3];
  logic [31:0] dlen [pps_pkg::DIV_STEPS+1];
  logic        dz [pps_pkg::DIV_STEPS+1];
  logic [2:0]  dn [pps_pkg::DIV_STEPS+1];
  logic signed [31:0] q32 [3];

  always_comb begin
    big = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = vec[i][32] ? 32'(-vec[i]) : vec[i][31:0];
      if (mag[i] > big) big = mag[i];
    end
  end

  always_comb begin
    lead = '0;
    for (int k = 0; k < 32; k++) begin
      if (s1_big[k]) lead = 5'(k);
    end
    for (int i = 0; i < 3; i++) begin
      if (s1_big[31]) nm[i] = s1_mag[i][31:1];
      else nm[i] = 31'(s1_mag[i] << (5'd30 - lead));
    end
  end

  assign len = isq[pps_pkg::ISQ_STEPS].r[31:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dvd[i] = 62'({pm[pps_pkg::ISQ_STEPS][i], 30'b0}) + 62'(len >> 1);
      q32[i] = $signed({1'b0, dv[pps_pkg::DIV_STEPS][i].quo});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_big  <= big;
      s2_zero <= (s1_big == '0);
      s2_neg  <= s1_neg;
      s3_zero <= s2_zero;
      s3_neg  <= s2_neg;
      for (int i = 0; i < 3; i++) begin
        s1_mag[i] <= mag[i];
        s1_neg[i] <= vec[i][32];
        s2_m[i]   <= nm[i];
        s3_sq[i]  <= 62'(s2_m[i]) * 62'(s2_m[i]);
        s3_m[i]   <= s2_m[i];
      end
      isq[0] <= '{x: 64'(s3_sq[0]) + 64'(s3_sq[1]) + 64'(s3_sq[2]), r: '0};
      pm[0]  <= s3_m;
      pz[0]  <= s3_zero;
      pn[0]  <= s3_neg;
      for (int k = 0; k < pps_pkg::ISQ_STEPS; k++) begin
        isq[k+1] <= pps_pkg::isq_step(isq[k], 64'd1 << (62 - 2 * k));
        pm[k+1]  <= pm[k];
        pz[k+1]  <= pz[k];
        pn[k+1]  <= pn[k];
      end
      for (int i = 0; i < 3; i++) begin
        dv[0][i] <= '{rem: 32'(dvd[i][61:31]), low: dvd[i][30:0], quo: '0};
      end
      dlen[0] <= len;
      dz[0]   <= pz[pps_pkg::ISQ_STEPS];
      dn[0]   <= pn[pps_pkg::ISQ_STEPS];
      for (int j = 0; j < pps_pkg::DIV_STEPS; j++) begin
        for (int i = 0; i < 3; i++) begin
          dv[j+1][i] <= pps_pkg::div_step(dv[j][i], dlen[j]);
        end
        dlen[j+1] <= dlen[j];
        dz[j+1]   <= dz[j];
        dn[j+1]   <= dn[j];
      end
      for (int i = 0; i < 3; i++) begin
        if (dz[pps_pkg::DIV_STEPS]) unit_vec[i] <= '0;
        else if (dn[pps_pkg::DIV_STEPS][i]) unit_vec[i] <= -q32[i];
        else unit_vec[i] <= q32[i];
      end
    end
  end

endmodule

// ----- rtl/pps_shade.sv -----
// shading pipeline: dot products, reflection cosine, seventh power, colour sum
module pps_shade (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [31:0] nrm [3],
  input  logic signed [31:0] eye_dir [3],
  input  logic signed [31:0] lgt_dir [3],
  input  logic [15:0]        color [3],
  input  pps_pkg::mode_t     mode,
  output logic               out_valid,
  output logic [15:0]        rgb [3]
);

  logic [pps_pkg::SHADE_LAT-1:0] vs;

  logic [16:0] wd;
  logic [31:0] spec_k;

  logic signed [63:0] prd [9];
  logic [15:0] col1 [3];

  logic signed [65:0] acc [3];
  logic signed [31:0] dot2 [3];
  logic [15:0] col2 [3];

  logic signed [63:0] nvnl3;
  logic signed [31:0] nl3, lv3;
  logic [32:0] wc3 [3];

  logic signed [64:0] t65;
  logic signed [35:0] rv_raw;
  logic [30:0] rv, nlc;
  logic [30:0] nlc4;
  logic [32:0] wc4 [3];

  logic [30:0] pw [7];
  logic [30:0] rvq [7];
  logic [63:0] difq [6][3];

  logic [63:0] spec11;
  logic [63:0] dif11 [3];
  logic [63:0] sum [3];
  logic [17:0] o18 [3];

  always_comb begin
    unique case (mode)
      pps_pkg::MODE_REFLECT: begin
        wd = '0;
        spec_k = pps_pkg::SPEC_ONE;
      end
      pps_pkg::MODE_FRESNEL: begin
        wd = pps_pkg::W_SIX;
        spec_k = pps_pkg::SPEC_FOUR;
      end
      default: begin
        wd = pps_pkg::W_ONE;
        spec_k = '0;
      end
    endcase
  end

  always_comb begin
    for (int d = 0; d < 3; d++) begin
      acc[d] = 66'(prd[3*d]) + 66'(prd[3*d+1]) + 66'(prd[3*d+2])
             + $signed(66'(pps_pkg::HALF_Q30));
    end
  end

  always_comb begin
    t65 = $signed({nvnl3, 1'b0}) + $signed(65'(pps_pkg::HALF_Q30));
    rv_raw = 36'(t65 >>> pps_pkg::UNIT_SHIFT) - 36'(lv3);
    if (rv_raw < 0) rv = '0;
    else if (rv_raw > $signed(36'(pps_pkg::UNIT_ONE))) rv = pps_pkg::UNIT_ONE;
    else rv = rv_raw[30:0];
    if (nl3 < 0) nlc = '0;
    else if (nl3 > $signed(32'(pps_pkg::UNIT_ONE))) nlc = pps_pkg::UNIT_ONE;
    else nlc = nl3[30:0];
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = dif11[i] + spec11 + pps_pkg::HALF_OUT;
      o18[i] = sum[i][63:46];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= '0;
    end else if (en) begin
      vs <= {vs[pps_pkg::SHADE_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        prd[i]   <= 64'(nrm[i]) * 64'(eye_dir[i]);
        prd[3+i] <= 64'(nrm[i]) * 64'(lgt_dir[i]);
        prd[6+i] <= 64'(lgt_dir[i]) * 64'(eye_dir[i]);
        dot2[i]  <= 32'(acc[i] >>> pps_pkg::UNIT_SHIFT);
        col1[i]  <= color[i];
        col2[i]  <= col1[i];
        wc3[i]   <= 33'(wd) * 33'(col2[i]);
        wc4[i]   <= wc3[i];
      end
      nvnl3 <= 64'(dot2[0]) * 64'(dot2[1]);
      nl3   <= dot2[1];
      lv3   <= dot2[2];
      pw[0]  <= rv;
      rvq[0] <= rv;
      nlc4   <= nlc;
      for (int k = 1; k < 7; k++) begin
        pw[k]  <= 31'((62'(pw[k-1]) * 62'(rvq[k-1]) + 62'(pps_pkg::HALF_Q30))
                      >> pps_pkg::UNIT_SHIFT);
        rvq[k] <= rvq[k-1];
      end
      for (int i = 0; i < 3; i++) begin
        difq[0][i] <= 64'(wc4[i]) * 64'(nlc4);
        for (int k = 1; k < 6; k++) begin
          difq[k][i] <= difq[k-1][i];
        end
        dif11[i] <= difq[5][i];
        rgb[i]   <= (o18[i] > 18'(pps_pkg::OUT_MAX)) ? pps_pkg::OUT_MAX : o18[i][15:0];
      end
      spec11 <= 64'(spec_k) * 64'(pw[6]);
    end
  end

  assign out_valid = vs[pps_pkg::SHADE_LAT-1];

endmodule

// ----- tb/sv/pps_tb_if.sv -----
`timescale 1ns / 100ps
// no testbench-only interfaces are needed; the channel interfaces come from the rtl
package pps_tb_types;
  typedef struct packed {
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic signed [31:0] norm_x, norm_y, norm_z;
    logic signed [31:0] eye_x, eye_y, eye_z;
    logic [15:0] base_red, base_green, base_blue;
  } sample_t;

  typedef struct packed {
    logic [15:0] red, green, blue;
  } shade_t;
endpackage

// ----- tb/sv/pps_checker.sv -----
`timescale 1ns / 100ps
// checker: watches the sample and pixel channels, predicts each shaded colour and compares
module pps_checker (
  input  logic        clk,
  input  logic        rst,
  pps_in_if.sink      sample,
  pps_out_if.sink     pixel,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  logic signed [63:0] light_at [3];
  logic [1:0] mode;
  pps_tb_types::shade_t expected_shades [$];

  function automatic logic [63:0] mag(logic signed [63:0] a);
    return a < 0 ? -a : a;
  endfunction

  function automatic logic signed [63:0] round_unit(logic signed [63:0] a);
    return (a + 64'sd536870912) >>> 30;
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] a);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > a) b = b >> 2;
    while (b != 0) begin
      if (a >= r + b) begin
        a = a - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void normalise(input logic signed [63:0] a [3],
                                    output logic signed [63:0] u [3]);
    logic [63:0] m [3];
    logic [63:0] big, len2, len, q;
    big = 0;
    len2 = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = mag(a[i]);
      if (m[i] > big) big = m[i];
    end
    if (big == 0) begin
      for (int i = 0; i < 3; i++) u[i] = 0;
      return;
    end
    while (big >= (64'd1 << 31)) begin
      big = big >> 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
    end
    while (big < (64'd1 << 30)) begin
      big = big << 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
    end
    for (int i = 0; i < 3; i++) len2 = len2 + m[i] * m[i];
    len = floor_sqrt(len2);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 30) + (len >> 1)) / len;
      u[i] = a[i] < 0 ? -$signed(q) : $signed(q);
    end
  endfunction

  function automatic logic signed [63:0] dot_unit(logic signed [63:0] a [3],
                                                  logic signed [63:0] b [3]);
    return round_unit(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]);
  endfunction

  function automatic logic signed [63:0] clamp_unit(logic signed [63:0] a);
    if (a < 0) return 0;
    if (a > (64'sd1 <<< 30)) return 64'sd1 <<< 30;
    return a;
  endfunction

  function automatic pps_tb_types::shade_t shade(pps_tb_types::sample_t s);
    logic signed [63:0] nr [3], ev [3], lv [3], n [3], v [3], l [3];
    logic signed [63:0] nv, nl, lvd, rv;
    logic [63:0] pw, wd, ws, spec, sum, o;
    logic [15:0] base [3];
    logic [15:0] res [3];
    pps_tb_types::shade_t r;
    nr = '{64'($signed(s.norm_x)), 64'($signed(s.norm_y)), 64'($signed(s.norm_z))};
    ev = '{64'($signed(s.eye_x)) - 64'($signed(s.pos_x)),
           64'($signed(s.eye_y)) - 64'($signed(s.pos_y)),
           64'($signed(s.eye_z)) - 64'($signed(s.pos_z))};
    lv = '{light_at[0] - 64'($signed(s.pos_x)), light_at[1] - 64'($signed(s.pos_y)),
           light_at[2] - 64'($signed(s.pos_z))};
    normalise(nr, n);
    normalise(ev, v);
    normalise(lv, l);
    nv = dot_unit(n, v);
    nl = dot_unit(n, l);
    lvd = dot_unit(l, v);
    rv = clamp_unit(round_unit(2 * nv * nl) - lvd);
    nl = clamp_unit(nl);
    pw = rv;
    for (int i = 0; i < 6; i++) pw = (pw * rv + pps_pkg::HALF_Q30) >> 30;
    case (mode)
      pps_pkg::MODE_REFLECT: begin wd = 0; ws = 65536; end
      pps_pkg::MODE_FRESNEL: begin wd = 39322; ws = 26214; end
      default: begin wd = 65536; ws = 0; end
    endcase
    spec = ws * 64'd52429 * pw;
    base = '{s.base_red, s.base_green, s.base_blue};
    for (int i = 0; i < 3; i++) begin
      sum = wd * base[i] * nl + spec;
      o = (sum + pps_pkg::HALF_OUT) >> 46;
      res[i] = o > 65535 ? pps_pkg::OUT_MAX : o[15:0];
    end
    r.red = res[0];
    r.green = res[1];
    r.blue = res[2];
    return r;
  endfunction

  task automatic report(input string msg);
    $display("mismatch %s at %0t", msg, $time);
    fail_count++;
  endtask

  always @(posedge clk) begin
    pps_tb_types::sample_t s;
    pps_tb_types::shade_t w;
    if (rst) begin
      light_at = '{0, 0, 0};
      mode <= pps_pkg::MODE_DIFFUSE;
      expected_shades.delete();
      fail_count = 0;
      pending <= 0;
    end else begin
      if (sample.valid && sample.ready) begin
        s = '{sample.pos_x, sample.pos_y, sample.pos_z, sample.norm_x, sample.norm_y,
              sample.norm_z, sample.eye_x, sample.eye_y, sample.eye_z,
              sample.base_red, sample.base_green, sample.base_blue};
        expected_shades.push_back(shade(s));
      end
      if (pixel.valid && pixel.ready) begin
        if (expected_shades.size() == 0) begin
          report("pixel transfer with nothing expected");
        end else begin
          w = expected_shades.pop_front();
          if (pixel.shade_red !== w.red)
            report($sformatf("red: got %0d expected %0d", pixel.shade_red, w.red));
          if (pixel.shade_green !== w.green)
            report($sformatf("green: got %0d expected %0d", pixel.shade_green, w.green));
          if (pixel.shade_blue !== w.blue)
            report($sformatf("blue: got %0d expected %0d", pixel.shade_blue, w.blue));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          pps_pkg::REG_LIGHT_X: light_at[0] = $signed(cfg_data);
          pps_pkg::REG_LIGHT_Y: light_at[1] = $signed(cfg_data);
          pps_pkg::REG_LIGHT_Z: light_at[2] = $signed(cfg_data);
          pps_pkg::REG_MODE:    mode <= cfg_data[1:0];
        endcase
      end
      pending <= expected_shades.size();
    end
  end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// top of the shader testbench: stimulus, idling phases, configuration and verdict
module tb;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [1:0] cfg_index = pps_pkg::REG_LIGHT_X;
  logic [31:0] cfg_data = 0;
  int fail_count, pending;
  int send_idle = 0, recv_stall = 0;
  bit hold_start = 0;
  bit hold_off = 0;

  pps_in_if  sample_ch();
  pps_out_if pixel_ch();

  phong_point_light_shader dut (
    .clk(clk), .rst(rst), .sample(sample_ch.sink), .pixel(pixel_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pps_checker chk (
    .clk(clk), .rst(rst), .sample(sample_ch.sink), .pixel(pixel_ch.sink),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always #4 clk = ~clk;

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) pixel_ch.ready <= 0;
    else if (hold_off) pixel_ch.ready <= 0;
    else pixel_ch.ready <= ($urandom_range(99) >= recv_stall);
  end

  // long receiver hold-off, counted here while the sender keeps offering
  initial begin
    wait (hold_start);
    @(posedge clk);
    hold_off <= 1;
    repeat (300) @(posedge clk);
    hold_off <= 0;
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      default: return 32'($signed($urandom_range(2000 << 16)) - (1000 << 16));
    endcase
  endfunction

  function automatic pps_tb_types::sample_t rand_sample();
    pps_tb_types::sample_t s;
    s.pos_x = rand_coord(); s.pos_y = rand_coord(); s.pos_z = rand_coord();
    s.norm_x = rand_coord(); s.norm_y = rand_coord(); s.norm_z = rand_coord();
    s.eye_x = rand_coord(); s.eye_y = rand_coord(); s.eye_z = rand_coord();
    if ($urandom_range(9) == 0) {s.norm_x, s.norm_y, s.norm_z} = '0;
    if ($urandom_range(9) == 0) {s.eye_x, s.eye_y, s.eye_z} = {s.pos_x, s.pos_y, s.pos_z};
    s.base_red = 16'($urandom); s.base_green = 16'($urandom); s.base_blue = 16'($urandom);
    return s;
  endfunction

  // one transfer on the sample channel, idling first as the phase asks
  task automatic send(input pps_tb_types::sample_t s);
    while ($urandom_range(99) < send_idle) begin
      sample_ch.valid <= 0;
      @(posedge clk);
    end
    sample_ch.valid <= 1;
    {sample_ch.pos_x, sample_ch.pos_y, sample_ch.pos_z, sample_ch.norm_x, sample_ch.norm_y,
     sample_ch.norm_z, sample_ch.eye_x, sample_ch.eye_y, sample_ch.eye_z,
     sample_ch.base_red, sample_ch.base_green, sample_ch.base_blue} <= s;
    do @(posedge clk); while (!sample_ch.ready);
  endtask

  task automatic drain();
    sample_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (pps_pkg::SHADE_LAT + pps_pkg::NORM_LAT + 10) @(posedge clk);
  endtask

  task automatic write_reg(input pps_pkg::reg_idx_t idx, input logic [31:0] d);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic configure(input logic [31:0] lx, ly, lz, input pps_pkg::mode_t m);
    write_reg(pps_pkg::REG_LIGHT_X, lx);
    write_reg(pps_pkg::REG_LIGHT_Y, ly);
    write_reg(pps_pkg::REG_LIGHT_Z, lz);
    write_reg(pps_pkg::REG_MODE, 32'(m));
  endtask

  initial begin
    pps_tb_types::sample_t s;
    int idle_phase [4];
    int stall_phase [4];
    idle_phase = '{0, 49, 0, 33};
    stall_phase = '{0, 0, 49, 33};
    sample_ch.valid = 0;
    {sample_ch.pos_x, sample_ch.pos_y, sample_ch.pos_z} = '0;
    {sample_ch.norm_x, sample_ch.norm_y, sample_ch.norm_z} = '0;
    {sample_ch.eye_x, sample_ch.eye_y, sample_ch.eye_z} = '0;
    {sample_ch.base_red, sample_ch.base_green, sample_ch.base_blue} = '0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: default config, then extremes
    s = '0;
    s.norm_z = 32'h0001_0000; s.eye_z = 32'h0005_0000;
    s.base_red = 16'hffff; s.base_green = 16'h8000; s.base_blue = 0;
    send(s);
    drain();
    for (int m = 0; m < 3; m++) begin
      configure(32'h0003_0000, 32'h0004_0000, 32'h0005_0000, pps_pkg::mode_t'(m));
      s = '0;
      s.norm_x = 32'h0000_0001; s.norm_y = 32'h0000_0001; s.norm_z = 32'h7fff_ffff;
      s.eye_x = 32'h0003_0000; s.eye_y = 32'h0004_0000; s.eye_z = 32'h0005_0000;
      s.base_red = 16'hffff; s.base_green = 16'h0001; s.base_blue = 16'h1234;
      send(s);
      s.norm_x = 0; s.norm_y = 0; s.norm_z = 0;
      send(s);
      s.norm_z = 32'h8000_0000; s.eye_x = 32'h8000_0000; s.eye_y = 32'h7fff_ffff;
      s.eye_z = 32'h8000_0000; s.pos_x = 32'h7fff_ffff; s.pos_z = 32'h7fff_ffff;
      send(s);
      s = '0;
      s.norm_z = 32'h0001_0000; s.eye_x = 32'h0003_0000; s.eye_y = 32'h0004_0000;
      s.eye_z = 32'h0005_0000;
      s.base_red = 16'hffff; s.base_green = 16'hffff; s.base_blue = 16'hffff;
      send(s);
      s.pos_x = 32'h0003_0000; s.pos_y = 32'h0004_0000; s.pos_z = 32'h0005_0000;
      send(s);
      s = rand_sample();
      send(s);
      drain();
    end
    configure(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, pps_pkg::mode_t'(2'd3));
    for (int i = 0; i < 3; i++) send(rand_sample());
    drain();

    // random phases over several light settings and modes
    for (int p = 0; p < 8; p++) begin
      send_idle = idle_phase[p % 4];
      recv_stall = stall_phase[p % 4];
      case (p)
        0: configure(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, pps_pkg::MODE_REFLECT);
        1: configure(0, 0, 0, pps_pkg::MODE_FRESNEL);
        default: configure(rand_coord(), rand_coord(), rand_coord(),
                           pps_pkg::mode_t'($urandom_range(3)));
      endcase
      if (p == 0) begin
        hold_start = 1;
        for (int i = 0; i < 50; i++) send(rand_sample());
      end
      for (int i = 0; i < 160; i++) send(rand_sample());
      drain();
    end

    if (fail_count == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb failed");
    $finish;
  end

endmodule
